[hw/rtl/atrp_pkg.sv]
`default_nettype none
package atrp_pkg;
    localparam int CNT_W   = 16;
    localparam int ACC_W   = 26;
    localparam int ANG_W   = 15;
    localparam int SCL_W   = 16;
    localparam int SQ_W    = 32;
    localparam int RT_N    = 28;
    localparam int REM_W   = 2 * RT_N;
    localparam int CRD_N   = 20;
    localparam int XY_W    = 32;
    localparam int Z_W     = 24;
    localparam int LAT     = 2 + RT_N + CRD_N + 1;
    localparam int ANG_MAX = 9000;

    typedef logic signed [CNT_W-1:0] t_cnt;
    typedef logic signed [ANG_W-1:0] t_ang;
    typedef logic signed [ACC_W-1:0] t_acc;

    // atan(2^-i) in 1/256 hundredth degree
    function automatic logic signed [Z_W-1:0] atan_lut(input logic [4:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            5'd0:  v = 24'sd1152000;
            5'd1:  v = 24'sd680065;
            5'd2:  v = 24'sd359328;
            5'd3:  v = 24'sd182400;
            5'd4:  v = 24'sd91554;
            5'd5:  v = 24'sd45822;
            5'd6:  v = 24'sd22916;
            5'd7:  v = 24'sd11459;
            5'd8:  v = 24'sd5730;
            5'd9:  v = 24'sd2865;
            5'd10: v = 24'sd1432;
            5'd11: v = 24'sd716;
            5'd12: v = 24'sd358;
            5'd13: v = 24'sd179;
            5'd14: v = 24'sd90;
            5'd15: v = 24'sd45;
            5'd16: v = 24'sd22;
            5'd17: v = 24'sd11;
            5'd18: v = 24'sd6;
            5'd19: v = 24'sd3;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

[hw/rtl/atrp_lane.sv]
`default_nettype none
module atrp_lane
    import atrp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_en,
    input  wire t_cnt i_num,
    input  wire t_cnt i_a,
    input  wire t_cnt i_b,
    output t_ang      o_angle
);
    // squares
    logic [SQ_W-1:0] r_sqa, r_sqb, r_sum;
    t_cnt            r_num0, r_num1;
    logic signed [2*CNT_W-1:0] n_sqa, n_sqb;

    assign n_sqa = i_a * i_a;
    assign n_sqb = i_b * i_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sqa  <= n_sqa;
            r_sqb  <= n_sqb;
            r_num0 <= i_num;
            r_sum  <= r_sqa + r_sqb;
            r_num1 <= r_num0;
        end
    end

    // bit-per-stage square root of sum << 24
    logic [REM_W-1:0] r_rem  [RT_N];
    logic [RT_N-1:0]  r_root [RT_N];
    t_cnt             r_numr [RT_N];

    genvar j;
    generate
        for (j = 0; j < RT_N; j++) begin : g_sqrt
            localparam int BB = RT_N - 1 - j;
            logic [REM_W-1:0] rem_in, trial;
            logic [RT_N-1:0]  root_in;
            t_cnt             num_in;
            if (j == 0) begin : g_first
                assign rem_in  = {r_sum, {(REM_W-SQ_W){1'b0}}};
                assign root_in = '0;
                assign num_in  = r_num1;
            end else begin : g_next
                assign rem_in  = r_rem[j-1];
                assign root_in = r_root[j-1];
                assign num_in  = r_numr[j-1];
            end
            assign trial = (REM_W'(root_in) << (BB + 1)) + (REM_W'(1) << (2 * BB));
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_numr[j] <= num_in;
                    if (rem_in >= trial) begin
                        r_rem[j]  <= rem_in - trial;
                        r_root[j] <= root_in | (RT_N'(1) << BB);
                    end else begin
                        r_rem[j]  <= rem_in;
                        r_root[j] <= root_in;
                    end
                end
            end
        end
    endgenerate

    // vectoring cordic
    logic signed [XY_W-1:0] r_x [CRD_N];
    logic signed [XY_W-1:0] r_y [CRD_N];
    logic signed [Z_W-1:0]  r_z [CRD_N];
    logic                   r_nz [CRD_N];

    genvar i;
    generate
        for (i = 0; i < CRD_N; i++) begin : g_crd
            logic signed [XY_W-1:0] x_in, y_in;
            logic signed [Z_W-1:0]  z_in;
            logic                   nz_in;
            if (i == 0) begin : g_first
                assign x_in  = XY_W'(r_root[RT_N-1]);
                assign y_in  = XY_W'(r_numr[RT_N-1]) <<< 12;
                assign z_in  = '0;
                assign nz_in = (r_numr[RT_N-1] != '0);
            end else begin : g_next
                assign x_in  = r_x[i-1];
                assign y_in  = r_y[i-1];
                assign z_in  = r_z[i-1];
                assign nz_in = r_nz[i-1];
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_nz[i] <= nz_in;
                    if (!y_in[XY_W-1]) begin
                        r_x[i] <= x_in + (y_in >>> i);
                        r_y[i] <= y_in - (x_in >>> i);
                        r_z[i] <= z_in + atan_lut(5'(i));
                    end else begin
                        r_x[i] <= x_in - (y_in >>> i);
                        r_y[i] <= y_in + (x_in >>> i);
                        r_z[i] <= z_in - atan_lut(5'(i));
                    end
                end
            end
        end
    endgenerate

    // round, clamp, zero numerator
    logic signed [Z_W:0]   zr;
    logic signed [Z_W-8:0] q;
    t_ang                  r_ang, n_ang;

    always_comb begin
        zr = (Z_W+1)'(r_z[CRD_N-1]) + (Z_W+1)'(128);
        q  = zr[Z_W:8];
        if (!r_nz[CRD_N-1]) n_ang = '0;
        else if (q > (Z_W-7)'(ANG_MAX)) n_ang = ANG_W'(ANG_MAX);
        else if (q < -(Z_W-7)'(ANG_MAX)) n_ang = -ANG_W'(ANG_MAX);
        else n_ang = ANG_W'(q);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_ang <= n_ang;
    end

    assign o_angle = r_ang;
endmodule
`default_nettype wire

[hw/rtl/accel_tilt_roll_pitch.sv]
// throughput: one item per cycle while the pipe is not stalled, with a fully
// pipelined square root and cordic
// the whole pipe advances together; it halts only while the output
// register holds a result that is not taken
// reset (synchronous, active low) clears the valid bits and loads the
// scale register with 2507
`default_nettype none
module accel_tilt_roll_pitch
    import atrp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // scale register write
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [SCL_W-1:0]  i_scale_per_count,
    // sample input
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_x_low,
    input  wire logic [7:0]        i_x_high,
    input  wire logic [7:0]        i_y_low,
    input  wire logic [7:0]        i_y_high,
    input  wire logic [7:0]        i_z_low,
    input  wire logic [7:0]        i_z_high,
    // result output
    output logic                   o_valid,
    input  wire logic              i_ready,
    output t_acc                   o_accel_x,
    output t_acc                   o_accel_y,
    output t_acc                   o_accel_z,
    output t_ang                   o_roll_angle,
    output t_ang                   o_pitch_angle
);
    logic [SCL_W-1:0] r_scale;
    logic [LAT-1:0]   r_vld;
    logic             adv;
    t_cnt             cx, cy, cz;

    // config always taken at once
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_scale <= SCL_W'(2507);
        else if (i_cfg_valid) r_scale <= i_scale_per_count;
    end

    // pipe moves when the output slot is empty or being drained
    assign adv     = !r_vld[LAT-1] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (adv) r_vld <= {r_vld[LAT-2:0], i_valid};
    end

    // signed counts from the byte pairs, low byte unsigned
    assign cx = {i_x_high, i_x_low};
    assign cy = {i_y_high, i_y_low};
    assign cz = {i_z_high, i_z_low};

    // scaled accelerations: one multiply, then a delay line to match the lanes
    logic signed [CNT_W+SCL_W:0] px, py, pz;
    t_acc r_ax [LAT];
    t_acc r_ay [LAT];
    t_acc r_az [LAT];

    assign px = cx * $signed({1'b0, r_scale});
    assign py = cy * $signed({1'b0, r_scale});
    assign pz = cz * $signed({1'b0, r_scale});

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // floor shift by 6
            r_ax[0] <= px[ACC_W+5:6];
            r_ay[0] <= py[ACC_W+5:6];
            r_az[0] <= pz[ACC_W+5:6];
            for (int k = 1; k < LAT; k++) begin
                r_ax[k] <= r_ax[k-1];
                r_ay[k] <= r_ay[k-1];
                r_az[k] <= r_az[k-1];
            end
        end
    end

    // roll lane: atan2(y, sqrt(x^2+z^2))
    atrp_lane u_roll (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_num   (cy),
        .i_a     (cx),
        .i_b     (cz),
        .o_angle (o_roll_angle)
    );

    // pitch lane: atan2(x, sqrt(y^2+z^2))
    atrp_lane u_pitch (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_num   (cx),
        .i_a     (cy),
        .i_b     (cz),
        .o_angle (o_pitch_angle)
    );

    // merge: accelerations and both angles leave together
    assign o_accel_x = r_ax[LAT-1];
    assign o_accel_y = r_ay[LAT-1];
    assign o_accel_z = r_az[LAT-1];
endmodule
`default_nettype wire

[hw/rtl/atrp_checker.sv]
`default_nettype none
module atrp_props
    import atrp_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_cfg_valid,
    input wire logic o_cfg_ready,
    input wire logic o_valid,
    input wire logic i_ready,
    input wire t_acc o_accel_x,
    input wire t_ang o_roll_angle,
    input wire t_ang o_pitch_angle
);
    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_accel_x) && $stable(o_roll_angle))
        else $error("stalled result changed");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_roll_angle <= ANG_W'(ANG_MAX)) && (o_roll_angle >= -ANG_W'(ANG_MAX))
                 && (o_pitch_angle <= ANG_W'(ANG_MAX)) && (o_pitch_angle >= -ANG_W'(ANG_MAX)))
        else $error("angle out of range");

    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config write refused");
endmodule

bind accel_tilt_roll_pitch atrp_props u_atrp_props (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_accel_x     (o_accel_x),
    .o_roll_angle  (o_roll_angle),
    .o_pitch_angle (o_pitch_angle)
);
`default_nettype wire
